@@ rtl/core/graph_five_coloring_search_macros.svh @@
// Assertion macros used by the coloring search RTL.
`ifndef GRAPH_FIVE_COLORING_SEARCH_MACROS_SVH
`define GRAPH_FIVE_COLORING_SEARCH_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define GFCS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gfcs assertion failed");

// Check that the consequent holds in the cycle after the antecedent.
`define GFCS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gfcs assertion failed");

`endif

@@ rtl/core/gfcs_pkg.sv @@
// Shared constants, types and helpers of the coloring search block.
package gfcs_pkg;

   localparam int DEF_MAX_VERTICES = 16;
   localparam int DEF_NUM_COLORS   = 5;

   // adjacency row width and the index width into one row
   localparam int MASK_W  = 16;
   localparam int MASK_IW = 4;

   // vertex index width wide enough for any vertex count in range
   localparam int IDX_W = 6;

   // control from the loader to the search sequencer
   typedef struct packed {
      logic              start;
      logic              ack;
      logic [IDX_W-1:0]  n;
      logic              wr_en;
      logic [IDX_W-1:0]  wr_addr;
      logic [MASK_W-1:0] wr_data;
   } gfcs_ctrl_type;

   // status from the search sequencer
   typedef struct packed {
      logic done;
      logic colorable;
   } gfcs_stat_type;

   // bit idx of an adjacency row; vertices past the row width read as zero
   function automatic logic mask_bit(input logic [MASK_W-1:0] mask,
                                     input logic [IDX_W-1:0]  idx);
      logic in_row;
      in_row = idx < IDX_W'(MASK_W);
      return in_row && mask[idx[MASK_IW-1:0]];
   endfunction

endpackage

@@ rtl/core/gfcs_req_if.sv @@
// Input channel carrying one adjacency row word.
interface gfcs_req_if;
   import gfcs_pkg::*;

   logic              valid;
   logic              ready;
   logic [MASK_W-1:0] neighbor_mask;
   logic              row_last;

   modport source (output valid, neighbor_mask, row_last, input ready);
   modport sink   (input valid, neighbor_mask, row_last, output ready);
endinterface

@@ rtl/core/gfcs_rsp_if.sv @@
// Result channel carrying one colorable word.
interface gfcs_rsp_if;
   logic valid;
   logic ready;
   logic colorable;

   modport source (output valid, colorable, input ready);
   modport sink   (input valid, colorable, output ready);
endinterface

@@ rtl/core/gfcs_search.sv @@
// Backtracking search sequencer with the row and color memories.
module gfcs_search #(
   parameter int MAX_VERTICES = gfcs_pkg::DEF_MAX_VERTICES,
   parameter int NUM_COLORS   = gfcs_pkg::DEF_NUM_COLORS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  gfcs_pkg::gfcs_ctrl_type ctrl,
   output gfcs_pkg::gfcs_stat_type stat
);
   import gfcs_pkg::*;

   localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int CW = $clog2(MAX_VERTICES + 1);
   localparam int KW = $clog2(NUM_COLORS + 1);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_VISIT = 6'b000010,
      S_LATCH = 6'b000100,
      S_TRYC  = 6'b001000,
      S_CHECK = 6'b010000,
      S_DONE  = 6'b100000
   } gfcs_seq_type;

   gfcs_seq_type      state_ff, state_in;
   logic [CW-1:0]     n_ff, n_in;
   logic [CW-1:0]     v_ff, v_in;
   logic [VW-1:0]     u_ff, u_in;
   logic [KW-1:0]     c_ff, c_in;
   logic              fwd_ff, fwd_in;
   logic              colorable_ff, colorable_in;
   logic [MASK_W-1:0] rowv_ff, rowv_in;

   logic [MASK_W-1:0] row_mem [MAX_VERTICES];
   logic [KW-1:0]     col_mem [MAX_VERTICES];
   logic [MASK_W-1:0] rd_row_ff;
   logic [KW-1:0]     rd_col_ff;

   logic [VW-1:0]     rd_addr;
   logic [VW-1:0]     v_idx;
   logic              col_we;
   logic              adj;
   logic              conflict;
   logic              exhausted;
   logic              last_u;

   assign v_idx     = v_ff[VW-1:0];
   assign adj       = mask_bit(rowv_ff, IDX_W'(u_ff)) | mask_bit(rd_row_ff, IDX_W'(v_ff));
   assign conflict  = (rd_col_ff == c_ff) && adj;
   assign exhausted = c_ff >= KW'(NUM_COLORS);
   assign last_u    = (CW'(u_ff) + CW'(1)) == v_ff;

   // row and color memories, registered read at one shared address
   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         row_mem[ctrl.wr_addr[VW-1:0]] <= ctrl.wr_data;
      end
      if (col_we) begin
         col_mem[v_idx] <= c_ff;
      end
      rd_row_ff <= row_mem[rd_addr];
      rd_col_ff <= col_mem[rd_addr];
   end

   // sequence the depth-first search one vertex compare per cycle
   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      v_in         = v_ff;
      u_in         = u_ff;
      c_in         = c_ff;
      fwd_in       = fwd_ff;
      colorable_in = colorable_ff;
      rowv_in      = rowv_ff;
      rd_addr      = v_idx;
      col_we       = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (ctrl.start) begin
               n_in     = ctrl.n[CW-1:0];
               v_in     = '0;
               fwd_in   = 1'b1;
               state_in = S_VISIT;
            end
         end
         S_VISIT: begin
            // every vertex colored: done
            if (v_ff >= n_ff) begin
               colorable_in = 1'b1;
               state_in     = S_DONE;
            end else begin
               state_in = S_LATCH;
            end
         end
         S_LATCH: begin
            // hold row v; resume past the stored color when stepping back
            rowv_in  = rd_row_ff;
            c_in     = fwd_ff ? '0 : rd_col_ff + KW'(1);
            state_in = S_TRYC;
         end
         S_TRYC: begin
            if (exhausted) begin
               if (v_ff == '0) begin
                  colorable_in = 1'b0;
                  state_in     = S_DONE;
               end else begin
                  v_in     = v_ff - CW'(1);
                  fwd_in   = 1'b0;
                  state_in = S_VISIT;
               end
            end else if (v_ff == '0) begin
               col_we   = 1'b1;
               v_in     = v_ff + CW'(1);
               fwd_in   = 1'b1;
               state_in = S_VISIT;
            end else begin
               u_in     = '0;
               rd_addr  = '0;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            // compare against earlier vertex u
            if (conflict) begin
               c_in     = c_ff + KW'(1);
               state_in = S_TRYC;
            end else if (last_u) begin
               col_we   = 1'b1;
               v_in     = v_ff + CW'(1);
               fwd_in   = 1'b1;
               state_in = S_VISIT;
            end else begin
               u_in    = u_ff + VW'(1);
               rd_addr = u_ff + VW'(1);
            end
         end
         S_DONE: begin
            if (ctrl.ack) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      n_ff         <= n_in;
      v_ff         <= v_in;
      u_ff         <= u_in;
      c_ff         <= c_in;
      fwd_ff       <= fwd_in;
      colorable_ff <= colorable_in;
      rowv_ff      <= rowv_in;
   end

   assign stat.done      = state_ff == S_DONE;
   assign stat.colorable = colorable_ff;

endmodule

@@ rtl/core/graph_five_coloring_search.sv @@
// Top level of the backtracking graph coloring search block.
//
// Adjacency rows enter one word per cycle in vertex order; the word with
// row_last set closes the graph and starts a depth-first search over up to
// MAX_VERTICES vertices with NUM_COLORS colors. The input stays not ready
// for the whole search. The search takes data-dependent time set by the
// single shared compare unit: each vertex is entered through the S_VISIT
// and S_LATCH states, then each color tried at vertex v passes S_TRYC and
// is compared against the earlier vertices one at a time through the row
// and color memory read port. A vertex that runs out of colors steps back
// from S_TRYC, and S_VISIT confirms success once every vertex is colored.
// The worst case grows exponentially with vertex count.
// The one-bit result goes to an output register once that register is free,
// so the next graph may start loading while it waits to be taken.
`include "graph_five_coloring_search_macros.svh"

module graph_five_coloring_search #(
   parameter int MAX_VERTICES = gfcs_pkg::DEF_MAX_VERTICES,
   parameter int NUM_COLORS   = gfcs_pkg::DEF_NUM_COLORS
) (
   input logic        clock,
   input logic        reset,
   gfcs_req_if.sink   req_chan,
   gfcs_rsp_if.source rsp_chan
);
   import gfcs_pkg::*;

   localparam int CW = $clog2(MAX_VERTICES + 1);

   typedef enum logic [1:0] {
      T_LOAD   = 2'b01,
      T_SEARCH = 2'b10
   } gfcs_top_type;

   gfcs_top_type  state_ff, state_in;
   logic [CW-1:0] rows_loaded_ff, rows_loaded_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          colorable_ff, colorable_in;
   logic [CW-1:0] rows_next;
   logic          req_accept;
   logic          room;

   gfcs_ctrl_type ctrl;
   gfcs_stat_type stat;

   gfcs_search #(
      .MAX_VERTICES (MAX_VERTICES),
      .NUM_COLORS   (NUM_COLORS)
   ) u_search (
      .clock (clock),
      .reset (reset),
      .ctrl  (ctrl),
      .stat  (stat)
   );

   assign req_chan.ready = state_ff == T_LOAD;
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign room           = rows_loaded_ff < CW'(MAX_VERTICES);
   assign rows_next      = room ? rows_loaded_ff + CW'(1) : rows_loaded_ff;

   // load rows, start the search, hand the result to the output register
   always_comb begin
      state_in       = state_ff;
      rows_loaded_in = rows_loaded_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      colorable_in   = colorable_ff;
      ctrl.start     = 1'b0;
      ctrl.ack       = 1'b0;
      ctrl.n         = IDX_W'(rows_next);
      ctrl.wr_en     = req_accept && room;
      ctrl.wr_addr   = IDX_W'(rows_loaded_ff);
      ctrl.wr_data   = req_chan.neighbor_mask;
      case (state_ff)
         T_LOAD: begin
            if (req_accept) begin
               rows_loaded_in = rows_next;
               if (req_chan.row_last) begin
                  ctrl.start     = 1'b1;
                  rows_loaded_in = '0;
                  state_in       = T_SEARCH;
               end
            end
         end
         T_SEARCH: begin
            // take the result once the output register is free
            if (stat.done && (!rsp_valid_ff || rsp_chan.ready)) begin
               ctrl.ack     = 1'b1;
               rsp_valid_in = 1'b1;
               colorable_in = stat.colorable;
               state_in     = T_LOAD;
            end
         end
         default: begin
            state_in = T_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= T_LOAD;
         rows_loaded_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         rows_loaded_ff <= rows_loaded_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      colorable_ff <= colorable_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.colorable = colorable_ff;

   // closing row starts the search
   `GFCS_ASSERT_NEXT(a_last_row_search, clock, reset, req_accept && req_chan.row_last, state_ff == T_SEARCH)
   // row count saturates at the vertex capacity
   `GFCS_ASSERT_NOW(a_rows_bound, clock, reset, 1'b1, rows_loaded_ff <= CW'(MAX_VERTICES))
   // an acknowledged result shows on the output next cycle
   `GFCS_ASSERT_NEXT(a_result_out, clock, reset, ctrl.ack, rsp_valid_ff && state_ff == T_LOAD)

endmodule
